@@ hdl/tcw_pkg.sv @@
// tcw_pkg: shared types, codes and defaults of the text console writer
// no dependencies; used by every module of the block
package tcw_pkg;

    // defaults for the top level parameters
    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int SCROLL_TOP_DEF = 6;
    localparam int CLEAR_TOP_DEF  = 5;
    localparam int TAB_WIDTH_DEF  = 8;

    // linear cell index: row (5 bits) times columns (up to 128) plus col (7 bits)
    localparam int IDX_W = 13;
    // cursor position before it is cut to the 11-bit result field
    localparam int POS_W = 13;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0]  ATTR_RESET = 8'h0F;
    localparam logic [15:0] INIT_WORD  = 16'h0F20;

    typedef enum logic [3:0] {
        OP_PUT_BS,
        OP_PUT_TAB,
        OP_PUT_CR,
        OP_PUT_LF,
        OP_PUT_CHAR,
        OP_PUT_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] idx;
        logic             idx_ok;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_REFRESH,
        ST_SCRL_RD,
        ST_SCRL_WR,
        ST_FILL,
        ST_READ
    } state_t;

endpackage

@@ hdl/text_console_writer.sv @@
// text console writer: 80x25 cell store with cursor, put/clear/write/read requests
// a printable character with a next cell adds the refresh state, an in-range read the read
// state; a scroll reads and writes each moved cell then blanks the last row, a clear blanks
// 1600 cells at the defaults, all set by the single-write cell store; throughput: 1 request
// per cycle while results are taken and the engine is idle, 2 more queue behind a long one
// reset: cursor 0, attribute 0x0F; full held high while every cell gets 0x0F20
module text_console_writer #(
    parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS       = tcw_pkg::ROWS_DEF,
    parameter int SCROLL_TOP = tcw_pkg::SCROLL_TOP_DEF,
    parameter int CLEAR_TOP  = tcw_pkg::CLEAR_TOP_DEF,
    parameter int TAB_WIDTH  = tcw_pkg::TAB_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [7:0]  char_code,
    input  logic [6:0]  col,
    input  logic [4:0]  row,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] cursor_pos,
    output logic [15:0] cell_data,
    input  logic        text_attribute_we,
    input  logic [7:0]  text_attribute
);

    logic          cmd_valid;
    tcw_pkg::cmd_t cmd;
    logic          cmd_pop;
    logic          busy;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .char_code (char_code),
        .col       (col),
        .row       (row),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tcw_engine #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .SCROLL_TOP (SCROLL_TOP),
        .CLEAR_TOP  (CLEAR_TOP),
        .TAB_WIDTH  (TAB_WIDTH)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop),
        .busy              (busy),
        .text_attribute_we (text_attribute_we),
        .text_attribute    (text_attribute),
        .empty             (empty),
        .pop               (pop),
        .cursor_pos        (cursor_pos),
        .cell_data         (cell_data)
    );

endmodule

@@ hdl/tcw_front.sv @@
// tcw_front: takes requests, classifies them and holds them in a two-entry queue
// depends on tcw_pkg
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    func,
    input  logic [7:0]    char_code,
    input  logic [6:0]    col,
    input  logic [4:0]    row,
    input  logic          busy,
    output logic          cmd_valid,
    output tcw_pkg::cmd_t cmd,
    input  logic          cmd_pop
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam logic [tcw_pkg::IDX_W-1:0] COLS_IDX = tcw_pkg::IDX_W'(COLUMNS);
    localparam logic [tcw_pkg::IDX_W:0]   CELLS_CMP = (tcw_pkg::IDX_W + 1)'(CELL_COUNT);

    tcw_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    tcw_pkg::cmd_t cls;
    logic          do_push;
    logic          do_pop;

    // classify the request on the way in
    always_comb
    begin
        cls           = '0;
        cls.char_code = char_code;
        cls.idx       = tcw_pkg::IDX_W'(row) * COLS_IDX + tcw_pkg::IDX_W'(col);
        cls.idx_ok    = {1'b0, cls.idx} < CELLS_CMP;
        unique case (func)
            tcw_pkg::FUNC_PUT:
            begin
                priority if (char_code == tcw_pkg::CH_BS)
                    cls.op = tcw_pkg::OP_PUT_BS;
                else if (char_code == tcw_pkg::CH_TAB)
                    cls.op = tcw_pkg::OP_PUT_TAB;
                else if (char_code == tcw_pkg::CH_CR)
                    cls.op = tcw_pkg::OP_PUT_CR;
                else if (char_code == tcw_pkg::CH_LF)
                    cls.op = tcw_pkg::OP_PUT_LF;
                else if (char_code >= tcw_pkg::CH_SPACE)
                    cls.op = tcw_pkg::OP_PUT_CHAR;
                else
                    cls.op = tcw_pkg::OP_PUT_NONE;
            end
            tcw_pkg::FUNC_CLEAR: cls.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::FUNC_WRITE: cls.op = tcw_pkg::OP_WRITE;
            tcw_pkg::FUNC_READ:  cls.op = tcw_pkg::OP_READ;
            default:             cls.op = tcw_pkg::OP_PUT_NONE;
        endcase
    end

    assign full      = (cnt_reg == 2'd2) || busy;
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= cls;
    end

endmodule

@@ hdl/tcw_engine.sv @@
// tcw_engine: cell store, cursor, command sequencer and two-entry result queue
// depends on tcw_pkg; fed by tcw_front
module tcw_engine #(
    parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS       = tcw_pkg::ROWS_DEF,
    parameter int SCROLL_TOP = tcw_pkg::SCROLL_TOP_DEF,
    parameter int CLEAR_TOP  = tcw_pkg::CLEAR_TOP_DEF,
    parameter int TAB_WIDTH  = tcw_pkg::TAB_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  tcw_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          busy,
    input  logic          text_attribute_we,
    input  logic [7:0]    text_attribute,
    output logic          empty,
    input  logic          pop,
    output logic [10:0]   cursor_pos,
    output logic [15:0]   cell_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int TW         = CW + 1;
    localparam int TAB_STOPS  = COLUMNS / TAB_WIDTH + 1;
    localparam bit DO_COPY    = (SCROLL_TOP + 1) < ROWS;
    localparam bit DO_CLEAR   = CLEAR_TOP < ROWS;

    localparam logic [AW-1:0] LAST_CELL   = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] COPY_LAST   = AW'(CELL_COUNT - COLUMNS - 1);
    localparam logic [AW-1:0] COPY_BASE   = AW'(DO_COPY ? SCROLL_TOP * COLUMNS : 0);
    localparam logic [AW-1:0] LAST_ROW_AT = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] CLEAR_BASE  = AW'(DO_CLEAR ? CLEAR_TOP * COLUMNS : 0);
    localparam logic [AW-1:0] COLS_AW     = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [RW-1:0] CLEAR_ROW   = RW'(DO_CLEAR ? CLEAR_TOP : ROWS - 1);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
    localparam logic [TW-1:0] COLS_TW     = TW'(COLUMNS);
    localparam logic [tcw_pkg::POS_W-1:0] COLS_POS = tcw_pkg::POS_W'(COLUMNS);
    localparam logic [tcw_pkg::POS_W:0]   CELLS_CMP = (tcw_pkg::POS_W + 1)'(CELL_COUNT);

    tcw_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic            scroll_pend_reg, scroll_pend_next;
    logic [7:0]      attr_reg;

    logic [15:0]     cells [CELL_COUNT];
    logic [15:0]     rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic [10:0]     res_pos_reg  [2];
    logic [15:0]     res_data_reg [2];
    logic            res_wr_reg, res_rd_reg;
    logic [1:0]      res_cnt_reg;
    logic            res_push;
    logic [15:0]     res_data;
    logic            res_pop;

    logic [tcw_pkg::POS_W-1:0] cur_pos;
    logic [tcw_pkg::POS_W-1:0] next_pos;
    logic [AW-1:0]   cur_idx;
    logic            next_in_range;
    logic [TW-1:0]   tab_stop;
    logic [15:0]     blank;
    logic            take;

    assign blank   = {attr_reg, tcw_pkg::CH_SPACE};
    assign cur_pos = tcw_pkg::POS_W'(row_reg) * COLS_POS + tcw_pkg::POS_W'(col_reg);
    assign cur_idx = cur_pos[AW-1:0];
    assign next_in_range = ({1'b0, cur_pos} + 14'd1) < CELLS_CMP;
    assign next_pos = tcw_pkg::POS_W'(row_next) * COLS_POS + tcw_pkg::POS_W'(col_next);

    // next tab stop: lowest multiple of the tab width above the column
    always_comb
    begin
        tab_stop = '0;
        for (int k = TAB_STOPS; k >= 1; k--)
        begin
            if (k * TAB_WIDTH > int'(col_reg))
                tab_stop = TW'(k * TAB_WIDTH);
        end
    end

    assign busy = (state_reg == tcw_pkg::ST_INIT);
    assign take = (state_reg == tcw_pkg::ST_IDLE) && cmd_valid && (res_cnt_reg != 2'd2);

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        scroll_pend_next = scroll_pend_reg;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = blank;
        mem_re           = 1'b0;
        mem_raddr        = ptr_reg;
        cmd_pop          = 1'b0;
        res_push         = 1'b0;
        res_data         = 16'd0;

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = tcw_pkg::INIT_WORD;
                ptr_next  = ptr_reg + AW'(1);
                if (ptr_reg == LAST_CELL)
                    state_next = tcw_pkg::ST_IDLE;
            end

            tcw_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        tcw_pkg::OP_PUT_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next  = col_reg - CW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = cur_idx - AW'(1);
                            end
                            res_push = 1'b1;
                        end
                        tcw_pkg::OP_PUT_TAB, tcw_pkg::OP_PUT_LF:
                        begin
                            priority if (cmd.op == tcw_pkg::OP_PUT_TAB && tab_stop < COLS_TW)
                            begin
                                col_next = tab_stop[CW-1:0];
                                res_push = 1'b1;
                            end
                            else if (row_reg != LAST_ROW)
                            begin
                                col_next = '0;
                                row_next = row_reg + RW'(1);
                                res_push = 1'b1;
                            end
                            else
                            begin
                                // new line on the last row: scroll
                                col_next   = '0;
                                ptr_next   = DO_COPY ? COPY_BASE : LAST_ROW_AT;
                                state_next = DO_COPY ? tcw_pkg::ST_SCRL_RD : tcw_pkg::ST_FILL;
                            end
                        end
                        tcw_pkg::OP_PUT_CR:
                        begin
                            col_next = '0;
                            res_push = 1'b1;
                        end
                        tcw_pkg::OP_PUT_CHAR:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_idx;
                            mem_wdata = {attr_reg, cmd.char_code};
                            if (col_reg == LAST_COL)
                            begin
                                col_next         = '0;
                                row_next         = (row_reg == LAST_ROW) ? row_reg
                                                                         : row_reg + RW'(1);
                                scroll_pend_next = (row_reg == LAST_ROW);
                            end
                            else
                            begin
                                col_next         = col_reg + CW'(1);
                                scroll_pend_next = 1'b0;
                            end
                            if (next_in_range)
                            begin
                                // refresh the attribute of the following cell
                                mem_re     = 1'b1;
                                mem_raddr  = cur_idx + AW'(1);
                                ptr_next   = cur_idx + AW'(1);
                                state_next = tcw_pkg::ST_REFRESH;
                            end
                            else
                            begin
                                // last cell written: column wraps on the last row
                                ptr_next   = DO_COPY ? COPY_BASE : LAST_ROW_AT;
                                state_next = DO_COPY ? tcw_pkg::ST_SCRL_RD : tcw_pkg::ST_FILL;
                            end
                        end
                        tcw_pkg::OP_PUT_NONE:
                            res_push = 1'b1;
                        tcw_pkg::OP_CLEAR:
                        begin
                            col_next = '0;
                            row_next = CLEAR_ROW;
                            if (DO_CLEAR)
                            begin
                                ptr_next   = CLEAR_BASE;
                                state_next = tcw_pkg::ST_FILL;
                            end
                            else
                                res_push = 1'b1;
                        end
                        tcw_pkg::OP_WRITE:
                        begin
                            mem_we    = cmd.idx_ok;
                            mem_waddr = cmd.idx[AW-1:0];
                            mem_wdata = {attr_reg, cmd.char_code};
                            res_push  = 1'b1;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            mem_re    = cmd.idx_ok;
                            mem_raddr = cmd.idx[AW-1:0];
                            if (cmd.idx_ok)
                                state_next = tcw_pkg::ST_READ;
                            else
                                res_push = 1'b1;
                        end
                        default:
                            res_push = 1'b1;
                    endcase
                end
            end

            tcw_pkg::ST_REFRESH:
            begin
                mem_we    = 1'b1;
                mem_wdata = {attr_reg, rd_data_reg[7:0]};
                if (scroll_pend_reg)
                begin
                    ptr_next   = DO_COPY ? COPY_BASE : LAST_ROW_AT;
                    state_next = DO_COPY ? tcw_pkg::ST_SCRL_RD : tcw_pkg::ST_FILL;
                end
                else
                begin
                    res_push   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            tcw_pkg::ST_SCRL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg + COLS_AW;
                state_next = tcw_pkg::ST_SCRL_WR;
            end

            tcw_pkg::ST_SCRL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                if (ptr_reg == COPY_LAST)
                begin
                    ptr_next   = LAST_ROW_AT;
                    state_next = tcw_pkg::ST_FILL;
                end
                else
                begin
                    ptr_next   = ptr_reg + AW'(1);
                    state_next = tcw_pkg::ST_SCRL_RD;
                end
            end

            tcw_pkg::ST_FILL:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == LAST_CELL)
                begin
                    res_push   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            tcw_pkg::ST_READ:
            begin
                res_data   = rd_data_reg;
                res_push   = 1'b1;
                state_next = tcw_pkg::ST_IDLE;
            end

            default:
                state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcw_pkg::ST_INIT;
            ptr_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            scroll_pend_reg <= 1'b0;
            attr_reg        <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            scroll_pend_reg <= scroll_pend_next;
            if (text_attribute_we)
                attr_reg <= text_attribute;
        end
    end

    // cell store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cells[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= cells[mem_raddr];
    end

    // result queue; a command starts only with a free slot, so a push always fits
    assign res_pop    = pop && (res_cnt_reg != 2'd0);
    assign empty      = (res_cnt_reg == 2'd0);
    assign cursor_pos = res_pos_reg[res_rd_reg];
    assign cell_data  = res_data_reg[res_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            res_wr_reg  <= res_wr_reg ^ res_push;
            res_rd_reg  <= res_rd_reg ^ res_pop;
            res_cnt_reg <= res_cnt_reg + 2'(res_push) - 2'(res_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_pos_reg[res_wr_reg]  <= next_pos[10:0];
            res_data_reg[res_wr_reg] <= res_data;
        end
    end

endmodule

@@ hdl/tcw_checker.sv @@
// tcw_checker: port-level assertions for the text console writer
// depends on tcw_pkg; bound to text_console_writer below
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [10:0] cursor_pos,
    input logic [15:0] cell_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    // the clearing pass holds off requests right after reset
    a_full_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> full)
        else $error("request accepted during the clearing pass");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty)
        else $error("result shown right after reset");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (int'(cursor_pos) < CELL_COUNT) || (CELL_COUNT > 2048))
        else $error("cursor position outside the screen");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cursor_pos) && $stable(cell_data)))
        else $error("waiting result changed before it was taken");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .cursor_pos (cursor_pos),
    .cell_data  (cell_data)
);
